// ----- rtl/mhgd_pkg.sv -----
package mhgd_pkg;

  // packet class codes as seen on the result word
  localparam logic [1:0] KIND_LDOWN = 2'd0;
  localparam logic [1:0] KIND_LUP   = 2'd1;
  localparam logic [1:0] KIND_MOVE  = 2'd2;

  // phase codes as seen on the result word
  localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_CODE_DRAW = 2'd1;
  localparam logic [1:0] PHASE_CODE_COMP = 2'd2;

  // first byte of a packet carries this bit, left button in bit 0
  localparam int FIRST_MARK_BIT = 3;
  localparam int LEFT_BTN_BIT   = 0;

  localparam int THR_W  = 15;
  localparam int SUM_W  = 16;
  localparam int IDX_W  = 2;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_LENGTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_DRIFT  = 2'd1;

  localparam logic [THR_W-1:0] LENGTH_RST = 15'd100;
  localparam logic [THR_W-1:0] DRIFT_RST  = 15'd10;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DRAW = 3'b010,
    PH_COMP = 3'b100
  } phase_t;

  // gesture state carried between packets
  typedef struct packed {
    phase_t                  phase;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
  } gest_state_t;

  // exact magnitude of a 17-bit signed value
  function automatic logic [SUM_W:0] abs17(input logic signed [SUM_W:0] v);
    logic [SUM_W:0] r;
    r = v[SUM_W] ? (SUM_W+1)'(-v) : (SUM_W+1)'(v);
    return r;
  endfunction

  function automatic logic [1:0] phase_code(input phase_t p);
    logic [1:0] c;
    unique case (p)
      PH_IDLE: c = PHASE_CODE_IDLE;
      PH_DRAW: c = PHASE_CODE_DRAW;
      PH_COMP: c = PHASE_CODE_COMP;
      default: c = PHASE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/mhgd_step.sv -----
module mhgd_step (
  input  logic [7:0]                       b0,
  input  logic [7:0]                       b1,
  input  logic [7:0]                       b2,
  input  logic [mhgd_pkg::THR_W-1:0]       length_thr,
  input  logic [mhgd_pkg::THR_W-1:0]       drift_tol,
  input  mhgd_pkg::gest_state_t            cur,
  output mhgd_pkg::gest_state_t            nxt,
  output logic [1:0]                       kind,
  output logic                             found
);

  logic signed [7:0]                dx;
  logic signed [7:0]                dy;
  logic signed [mhgd_pkg::SUM_W:0]  sx_ext;
  logic signed [mhgd_pkg::SUM_W:0]  sy_ext;
  logic signed [mhgd_pkg::SUM_W:0]  sx_trial;
  logic signed [mhgd_pkg::SUM_W-1:0] add_x;
  logic signed [mhgd_pkg::SUM_W-1:0] add_y;
  logic [mhgd_pkg::SUM_W:0]         len_ext;
  logic [mhgd_pkg::SUM_W:0]         tol_ext;
  logic                             reversal;

  assign dx = signed'(b1);
  assign dy = signed'(b2);

  // packet class
  always_comb begin
    if (b1 == 8'd0 && b2 == 8'd0) begin
      kind = b0[mhgd_pkg::LEFT_BTN_BIT] ? mhgd_pkg::KIND_LDOWN : mhgd_pkg::KIND_LUP;
    end else begin
      kind = mhgd_pkg::KIND_MOVE;
    end
  end

  // x reversal test, taken without wrap
  assign len_ext  = {2'b00, length_thr};
  assign tol_ext  = {2'b00, drift_tol};
  assign sx_ext   = {cur.sum_x[mhgd_pkg::SUM_W-1], cur.sum_x};
  assign sy_ext   = {cur.sum_y[mhgd_pkg::SUM_W-1], cur.sum_y};
  assign sx_trial = sx_ext + (mhgd_pkg::SUM_W+1)'(dx);
  assign reversal = (mhgd_pkg::abs17(sx_trial) < mhgd_pkg::abs17(sx_ext)) &&
                    (mhgd_pkg::abs17(sy_ext) > tol_ext);

  // wrapping accumulation
  assign add_x = cur.sum_x + mhgd_pkg::SUM_W'(dx);
  assign add_y = cur.sum_y + mhgd_pkg::SUM_W'(dy);

  // gesture phase update
  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      mhgd_pkg::PH_IDLE: begin
        nxt.sum_x = '0;
        nxt.sum_y = '0;
        if (kind == mhgd_pkg::KIND_LDOWN) begin
          nxt.phase = mhgd_pkg::PH_DRAW;
        end
      end
      mhgd_pkg::PH_DRAW: begin
        if (kind == mhgd_pkg::KIND_MOVE) begin
          if (reversal) begin
            nxt.sum_x = '0;
            nxt.sum_y = '0;
          end else begin
            nxt.sum_x = add_x;
            nxt.sum_y = add_y;
            if (mhgd_pkg::abs17({add_x[mhgd_pkg::SUM_W-1], add_x}) >= len_ext) begin
              nxt.phase = mhgd_pkg::PH_COMP;
            end
          end
        end else if (kind == mhgd_pkg::KIND_LUP) begin
          nxt.phase = mhgd_pkg::PH_IDLE;
        end
      end
      mhgd_pkg::PH_COMP: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // detection on the updated sums
  assign found =
    (mhgd_pkg::abs17({nxt.sum_x[mhgd_pkg::SUM_W-1], nxt.sum_x}) >= len_ext) &&
    (mhgd_pkg::abs17({nxt.sum_y[mhgd_pkg::SUM_W-1], nxt.sum_y}) < tol_ext);

endmodule

// ----- rtl/mouse_horizontal_gesture_detector_top.sv -----
// result word: registered, valid in the cycle after the third byte of a packet is taken
// throughput: one byte per cycle; first and second bytes never stall, the
//   third stalls only while a result word is held by a stalled output
// reset (synchronous, rst_n low): framing expects a first byte, phase idle,
//   sums and detected flag cleared, thresholds back to 100 and 10
module mouse_horizontal_gesture_detector_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_event_kind,
  output logic signed [7:0]             out_x_delta,
  output logic signed [7:0]             out_y_delta,
  output logic signed [15:0]            out_x_sum,
  output logic signed [15:0]            out_y_sum,
  output logic [1:0]                    out_gesture_phase,
  output logic                          out_gesture_detected,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mhgd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mhgd_pkg::THR_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    POS_FIRST  = 3'b001,
    POS_SECOND = 3'b010,
    POS_THIRD  = 3'b100
  } pos_t;

  pos_t                         pos_r, pos_nxt;
  logic [7:0]                   held0_r, held1_r;
  mhgd_pkg::gest_state_t        gst_r, gst_nxt;
  logic                         found_r, found_nxt;
  logic [mhgd_pkg::THR_W-1:0]   len_r, tol_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   kind_r;
  logic signed [7:0]            xd_r, yd_r;
  logic signed [15:0]           xs_r, ys_r;
  logic [1:0]                   ph_r;
  logic                         det_r;

  mhgd_pkg::gest_state_t        step_nxt;
  logic [1:0]                   step_kind;
  logic                         step_found;
  logic                         accept;
  logic                         live;
  logic                         load_out;
  logic                         load_b0;
  logic                         load_b1;

  assign cfg_ready = 1'b1;

  // third byte waits only on a full, stalled output register
  assign in_stall = out_valid_r && out_stall && (pos_r == POS_THIRD) && !found_r;
  assign accept   = in_valid && !in_stall;
  assign live     = accept && !found_r;

  mhgd_step u_step (
    .b0         (held0_r),
    .b1         (held1_r),
    .b2         (in_data_byte),
    .length_thr (len_r),
    .drift_tol  (tol_r),
    .cur        (gst_r),
    .nxt        (step_nxt),
    .kind       (step_kind),
    .found      (step_found)
  );

  // packet framing
  always_comb begin
    pos_nxt   = pos_r;
    gst_nxt   = gst_r;
    found_nxt = found_r;
    load_out  = 1'b0;
    load_b0   = 1'b0;
    load_b1   = 1'b0;
    if (live) begin
      unique case (pos_r)
        POS_FIRST: begin
          if (in_data_byte[mhgd_pkg::FIRST_MARK_BIT]) begin
            load_b0 = 1'b1;
            pos_nxt = POS_SECOND;
          end
        end
        POS_SECOND: begin
          load_b1 = 1'b1;
          pos_nxt = POS_THIRD;
        end
        POS_THIRD: begin
          pos_nxt   = POS_FIRST;
          gst_nxt   = step_nxt;
          found_nxt = step_found;
          load_out  = 1'b1;
        end
        default: begin
          pos_nxt = POS_FIRST;
        end
      endcase
    end
  end

  // output word handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_FIRST;
      gst_r.phase <= mhgd_pkg::PH_IDLE;
      gst_r.sum_x <= '0;
      gst_r.sum_y <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= mhgd_pkg::LENGTH_RST;
      tol_r       <= mhgd_pkg::DRIFT_RST;
    end else begin
      pos_r       <= pos_nxt;
      gst_r       <= gst_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mhgd_pkg::REG_LENGTH) begin
          len_r <= cfg_data;
        end else if (cfg_index == mhgd_pkg::REG_DRIFT) begin
          tol_r <= cfg_data;
        end
      end
    end
  end

  // held bytes and result word payload
  always_ff @(posedge clk) begin
    if (load_b0) begin
      held0_r <= in_data_byte;
    end
    if (load_b1) begin
      held1_r <= in_data_byte;
    end
    if (load_out) begin
      kind_r <= step_kind;
      xd_r   <= signed'(held1_r);
      yd_r   <= signed'(in_data_byte);
      xs_r   <= step_nxt.sum_x;
      ys_r   <= step_nxt.sum_y;
      ph_r   <= mhgd_pkg::phase_code(step_nxt.phase);
      det_r  <= step_found;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_event_kind       = kind_r;
  assign out_x_delta          = xd_r;
  assign out_y_delta          = yd_r;
  assign out_x_sum            = xs_r;
  assign out_y_sum            = ys_r;
  assign out_gesture_phase    = ph_r;
  assign out_gesture_detected = det_r;

endmodule
